// ===== rtl/rle8_pkg.sv =====
`timescale 1ns / 1ps

package rle8_pkg;

    // longest run one count byte can hold
    localparam logic [7:0] RUN_LIMIT = 8'd255;

    // escape bytes of the encoded stream
    localparam logic [7:0] ESC_MARK = 8'h00;
    localparam logic [7:0] ESC_EOL  = 8'h00;
    localparam logic [7:0] ESC_EOI  = 8'h01;

    // most bytes one pixel can produce: closed run, final run, end of row, end of image
    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // bytes produced by one pixel, lowest entry goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
    } t_pack;

endpackage

// ===== rtl/rle8_if.sv =====
`timescale 1ns / 1ps

// pixel request channel
interface rle8_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;

    modport source (output valid, output pixel, output row_end, output image_end,
                    input ready);
    modport sink   (input valid, input pixel, input row_end, input image_end,
                    output ready);
endinterface

// encoded byte channel
interface rle8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/rle8_run_encoder.sv =====
`timescale 1ns / 1ps

// rle8 run encoder: takes one 8-bit palette-index pixel per request, with
// row-end and image-end marks, and produces the encoded-mode byte stream of
// bmp rle8 as (count, value) pairs. a run is closed by a change of value, by
// one more equal pixel once it holds 255, or by a row end; a row end adds the
// escape pair 0,0 and an image end (which also ends the row) adds 0,1 after
// it. a pixel that only extends a run produces no bytes. the last byte caused
// by each pixel carries last=1. a pixel request is taken in every cycle while
// the output side keeps up; the byte port moves one byte per cycle while the
// sink is ready, so a pixel that produces k bytes holds the output until all
// k are out (2 for a plain run change, up to 8 at an image end); the input
// stalls only when the pending pack register and the output shift register
// are both occupied; bytes go via the pack register to the shifter. no parameters.
module rle8_run_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rle8_pix_if.sink     i_pix,
    rle8_byte_if.source  o_byte
);

    // run state
    logic [7:0] r_prev;
    logic [7:0] r_run;
    logic       r_open;
    logic [7:0] n_prev;
    logic [7:0] n_run;
    logic       n_open;

    // pack computed from the accepted pixel
    rle8_pkg::t_pack n_pack;

    // stage a: pack waiting for the output shifter
    rle8_pkg::t_pack r_a;
    logic            r_a_valid;

    // stage b: output shifter, entry 0 is on the port
    logic [rle8_pkg::MAX_BYTES-1:0][7:0] r_b_bytes;
    logic [rle8_pkg::CNT_W-1:0]          r_b_cnt;
    logic                                r_b_valid;

    logic accept;
    logic take;
    logic b_done;
    logic a_move;

    assign take   = o_byte.valid && o_byte.ready;
    assign b_done = take && (r_b_cnt == rle8_pkg::CNT_W'(1));
    // the pack moves down when the shifter is empty or hands out its last byte now
    assign a_move = r_a_valid && (!r_b_valid || b_done);

    assign i_pix.ready = !r_a_valid || a_move;
    assign accept      = i_pix.valid && i_pix.ready;

    assign o_byte.valid    = r_b_valid;
    assign o_byte.out_byte = r_b_bytes[0];
    assign o_byte.last     = (r_b_cnt == rle8_pkg::CNT_W'(1));

    // run update and byte list for one pixel
    always_comb begin
        logic [rle8_pkg::CNT_W-1:0] idx;
        logic                       ends;
        idx    = '0;
        ends   = i_pix.row_end || i_pix.image_end;
        n_pack = '0;
        n_prev = r_prev;
        n_run  = r_run;
        n_open = r_open;

        priority if (!r_open) begin
            // first pixel of a row opens a run
            n_prev = i_pix.pixel;
            n_run  = 8'd1;
            n_open = 1'b1;
        end else if (i_pix.pixel == r_prev) begin
            if (r_run >= rle8_pkg::RUN_LIMIT) begin
                // full run goes out, the pixel starts a new one
                n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = rle8_pkg::RUN_LIMIT;
                idx = idx + rle8_pkg::CNT_W'(1);
                n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = i_pix.pixel;
                idx = idx + rle8_pkg::CNT_W'(1);
                n_run = 8'd1;
            end else begin
                n_run = r_run + 8'd1;
            end
        end else begin
            // value changed: close the open run
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = r_run;
            idx = idx + rle8_pkg::CNT_W'(1);
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = r_prev;
            idx = idx + rle8_pkg::CNT_W'(1);
            n_prev = i_pix.pixel;
            n_run  = 8'd1;
        end

        if (ends) begin
            // flush the run, then end of row
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = n_run;
            idx = idx + rle8_pkg::CNT_W'(1);
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = n_prev;
            idx = idx + rle8_pkg::CNT_W'(1);
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = rle8_pkg::ESC_MARK;
            idx = idx + rle8_pkg::CNT_W'(1);
            n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = rle8_pkg::ESC_EOL;
            idx = idx + rle8_pkg::CNT_W'(1);
            if (i_pix.image_end) begin
                n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = rle8_pkg::ESC_MARK;
                idx = idx + rle8_pkg::CNT_W'(1);
                n_pack.bytes[idx[rle8_pkg::IDX_W-1:0]] = rle8_pkg::ESC_EOI;
                idx = idx + rle8_pkg::CNT_W'(1);
            end
            n_open = 1'b0;
            n_run  = 8'd0;
            n_prev = 8'd0;
        end
        n_pack.cnt = idx;
    end

    // run state advances on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_run  <= '0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_run  <= n_run;
            r_open <= n_open;
        end
    end

    // stage a: only packs with bytes are kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= (r_a_valid && !a_move) || (accept && (n_pack.cnt != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (n_pack.cnt != '0)) begin
            r_a <= n_pack;
        end
    end

    // stage b: load a pack or shift one byte out per taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_cnt   <= '0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
            r_b_cnt   <= r_a.cnt;
        end else if (take) begin
            r_b_cnt <= r_b_cnt - rle8_pkg::CNT_W'(1);
            if (b_done) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_bytes <= r_a.bytes;
        end else if (take) begin
            r_b_bytes <= r_b_bytes >> 8;
        end
    end

endmodule
